[src/spru_pkg.sv]
// Shared types and codes for the breakpoint table range-update block.
`timescale 1ns / 1ps
package spru_pkg;
    localparam int TimeW  = 31;
    localparam int CountW = 16;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_ADJ_RD,
        ST_ADJ_WR,
        ST_READ,
        ST_DONE
    } t_state;

    // one breakpoint as stored in the table
    typedef struct packed {
        logic [TimeW-1:0]  bp_time;
        logic [CountW-1:0] bp_count;
    } t_entry;

    // memory port request from the sequencer
    typedef struct packed {
        logic   wr_en;
        t_entry wr_data;
    } t_mem_req;
endpackage

[src/spru_table.sv]
// Breakpoint table memory, one write and one registered read port.
`timescale 1ns / 1ps
module spru_table #(
    parameter int AW = 6
) (
    input  logic                i_clk,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  spru_pkg::t_mem_req  i_req,
    output spru_pkg::t_entry    o_rd_data
);
    spru_pkg::t_entry mem [2**AW];
    spru_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[src/step_profile_range_update.sv]
// Top level: sorted breakpoint table with +1/-1 range updates.
//
// channel | dir | handshake            | payload
// in      | in  | i_valid / o_ready    | operation, begin/end time, direction, index
// out     | out | o_valid / i_ready    | entry time/count, entries used, rejected
//
// One word at a time. An update first scans the table for both of its points
// to check for room. It then places each point: a fresh scan, a shift up by
// one of every entry at or above the insert point if the point is new, and
// the step added to every entry from it onward. Every walk reads one entry
// at a time through the single memory read port.
// Synchronous active-low reset empties the table count; contents are left.
// The result sits in the output register; o_ready stays low until taken.
`timescale 1ns / 1ps
module step_profile_range_update #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [30:0] i_begin_time,
    input  logic [30:0] i_end_time,
    input  logic        i_direction,
    input  logic [5:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [30:0] o_entry_time,
    output logic [15:0] o_entry_count,
    output logic [6:0]  o_entries_used,
    output logic        o_rejected
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    spru_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_used, n_used;     // valid breakpoints
    logic [CW-1:0]    r_ptr, n_ptr;       // walk pointer
    logic [CW-1:0]    r_pos, n_pos;       // insert/locate position
    logic             r_second, n_second; // placing the end breakpoint
    logic             r_hit_b, n_hit_b;   // begin already present (scan 1)
    logic             r_pass, n_pass;     // 0 = feasibility pass, 1 = place
    logic [15:0]      r_prev, n_prev;     // count just below position
    logic [15:0]      r_step, n_step;
    logic [30:0]      r_begin, r_end;
    logic             r_ovalid, n_ovalid;
    logic [30:0]      r_otime, n_otime;
    logic [15:0]      r_ocount, n_ocount;
    logic             r_orej, n_orej;

    logic [AW-1:0]      rd_addr, wr_addr;
    spru_pkg::t_mem_req req;
    spru_pkg::t_entry   rd_data;
    logic [30:0]        key;
    logic               accept;

    spru_table #(.AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    assign o_ready = (r_state == spru_pkg::ST_IDLE) && !r_ovalid;
    assign accept  = i_valid && o_ready;
    assign key     = r_second ? r_end : r_begin;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_begin <= i_begin_time;
            r_end   <= i_end_time;
        end
        r_ptr    <= n_ptr;
        r_pos    <= n_pos;
        r_prev   <= n_prev;
        r_step   <= n_step;
        r_hit_b  <= n_hit_b;
        r_otime  <= n_otime;
        r_ocount <= n_ocount;
        r_orej   <= n_orej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spru_pkg::ST_IDLE;
            r_used   <= '0;
            r_second <= 1'b0;
            r_pass   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_second <= n_second;
            r_pass   <= n_pass;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        logic [CW-1:0] need;
        logic          hit;
        n_state  = r_state;
        n_used   = r_used;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_second = r_second;
        n_hit_b  = r_hit_b;
        n_pass   = r_pass;
        n_prev   = r_prev;
        n_step   = r_step;
        n_ovalid = r_ovalid;
        n_otime  = r_otime;
        n_ocount = r_ocount;
        n_orej   = r_orej;
        rd_addr  = r_ptr[AW-1:0];
        wr_addr  = r_ptr[AW-1:0];
        req      = '0;
        need     = '0;
        hit      = (r_pos < r_used);
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_state)
            spru_pkg::ST_IDLE: begin
                if (accept) begin
                    n_otime  = '0;
                    n_ocount = '0;
                    n_orej   = 1'b0;
                    n_ptr    = '0;
                    n_second = 1'b0;
                    n_pass   = 1'b0;
                    n_step   = i_direction ? 16'h0001 : 16'hFFFF;
                    rd_addr  = AW'(i_entry_index);
                    unique case (spru_pkg::t_op'(i_operation))
                        spru_pkg::OP_UPDATE: begin
                            if (i_begin_time >= i_end_time) begin
                                n_orej   = 1'b1;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = spru_pkg::ST_SCAN;
                            end
                        end
                        spru_pkg::OP_READ: begin
                            if (32'(i_entry_index) < 32'(r_used)) begin
                                n_state = spru_pkg::ST_READ;
                            end else begin
                                n_orej   = 1'b1;
                                n_ovalid = 1'b1;
                            end
                        end
                        spru_pkg::OP_CLEAR: begin
                            n_used   = '0;
                            n_ovalid = 1'b1;
                        end
                        default: begin
                            n_orej   = 1'b1;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            spru_pkg::ST_READ: begin
                n_otime  = rd_data.bp_time;
                n_ocount = rd_data.bp_count;
                n_ovalid = 1'b1;
                n_state  = spru_pkg::ST_IDLE;
            end
            // issue read of r_ptr, or finish locate at end of table
            spru_pkg::ST_SCAN: begin
                if (r_ptr >= r_used) begin
                    n_pos   = r_ptr;
                    n_state = spru_pkg::ST_DECIDE;
                end else begin
                    n_state = spru_pkg::ST_ADJ_RD;
                end
            end
            // r_pos located; r_prev holds count below it; rd_data at r_pos
            spru_pkg::ST_DECIDE: begin
                hit = (r_pos < r_used) && (rd_data.bp_time == key);
                if (!r_pass) begin
                    if (!r_second) begin
                        n_hit_b  = hit;
                        n_second = 1'b1;
                        n_ptr    = '0;
                        n_state  = spru_pkg::ST_SCAN;
                    end else begin
                        need = CW'(!r_hit_b) + CW'(!hit);
                        if ({1'b0, r_used} + {1'b0, need} > (CW+1)'(TABLE_DEPTH)) begin
                            n_orej   = 1'b1;
                            n_ovalid = 1'b1;
                            n_state  = spru_pkg::ST_IDLE;
                        end else begin
                            n_pass   = 1'b1;
                            n_second = 1'b0;
                            n_ptr    = '0;
                            n_state  = spru_pkg::ST_SCAN;
                        end
                    end
                end else if (hit) begin
                    n_ptr   = r_pos;
                    n_state = spru_pkg::ST_ADJ_WR;
                end else begin
                    // shift [pos, used) up from the top
                    n_ptr   = r_used;
                    n_state = spru_pkg::ST_SHIFT_RD;
                end
            end
            spru_pkg::ST_SHIFT_RD: begin
                if (r_ptr == r_pos) begin
                    req.wr_en   = 1'b1;
                    wr_addr     = r_pos[AW-1:0];
                    req.wr_data = '{bp_time: key, bp_count: r_prev};
                    n_used      = r_used + 1'b1;
                    n_state     = spru_pkg::ST_ADJ_WR;
                end else begin
                    rd_addr = AW'(r_ptr - 1'b1);
                    n_state = spru_pkg::ST_SHIFT_WR;
                end
            end
            spru_pkg::ST_SHIFT_WR: begin
                req.wr_en   = 1'b1;
                req.wr_data = rd_data;
                n_ptr       = r_ptr - 1'b1;
                n_state     = spru_pkg::ST_SHIFT_RD;
            end
            // ADJ_RD doubles as scan compare step before placement
            spru_pkg::ST_ADJ_RD: begin
                if (rd_data.bp_time < key) begin
                    n_prev  = rd_data.bp_count;
                    n_ptr   = r_ptr + 1'b1;
                    n_state = spru_pkg::ST_SCAN;
                end else begin
                    n_pos   = r_ptr;
                    rd_addr = r_ptr[AW-1:0];
                    n_state = spru_pkg::ST_DECIDE;
                end
            end
            // walk counts from r_ptr up, adding step: read then write
            spru_pkg::ST_ADJ_WR: begin
                if (r_ptr >= r_used) begin
                    if (!r_second) begin
                        n_second = 1'b1;
                        n_step   = 16'd0 - r_step;
                        n_ptr    = '0;
                        n_prev   = '0;
                        n_state  = spru_pkg::ST_SCAN;
                    end else begin
                        n_ovalid = 1'b1;
                        n_state  = spru_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = spru_pkg::ST_DONE;
                end
            end
            spru_pkg::ST_DONE: begin
                req.wr_en   = 1'b1;
                req.wr_data = '{bp_time: rd_data.bp_time,
                                bp_count: rd_data.bp_count + r_step};
                n_ptr       = r_ptr + 1'b1;
                rd_addr     = AW'(r_ptr + 1'b1);
                n_state     = spru_pkg::ST_ADJ_WR;
            end
            default: n_state = spru_pkg::ST_IDLE;
        endcase
        if (r_state == spru_pkg::ST_SCAN && r_ptr < r_used) rd_addr = r_ptr[AW-1:0];
        if (r_state == spru_pkg::ST_DECIDE && r_pass && hit) rd_addr = r_pos[AW-1:0];
        if (r_state == spru_pkg::ST_SHIFT_RD && r_ptr == r_pos) rd_addr = AW'(r_pos + 1'b1);
        if (r_state == spru_pkg::ST_SCAN && r_ptr == '0) n_prev = '0;
    end

    assign o_valid        = r_ovalid;
    assign o_entry_time   = r_otime;
    assign o_entry_count  = r_ocount;
    assign o_entries_used = 7'(r_used);
    assign o_rejected     = r_orej;
endmodule

[src/spru_checker.sv]
// Port-level checker for the range-update block, with its bind.
`timescale 1ns / 1ps
module spru_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  i_operation,
    input logic [6:0]  o_entries_used,
    input logic        o_rejected,
    input logic [30:0] o_entry_time
);
    a_no_ready_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entries_used))
        else $error("result changed while stalled");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_operation == spru_pkg::OP_CLEAR |=> o_entries_used == 7'd0)
        else $error("clear left entries");
    a_rej_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_entry_time == 31'd0)
        else $error("rejected word carries data");
endmodule

bind step_profile_range_update spru_checker u_spru_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .i_operation(i_operation),
    .o_entries_used(o_entries_used), .o_rejected(o_rejected),
    .o_entry_time(o_entry_time)
);
